### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ITRD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ITRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/itrd_pkg.sv
// ---------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants and helpers of the integer to radix text converter.
// ---------------------------------------------------------------------------
package itrd_pkg;

  // Field widths.
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  // Radix limits and reset value.
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS      = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE       = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_LETTER_OFS = 7'h37;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 7'h5A;
  localparam logic [DIGIT_W-1:0] DIGIT_DEC_MAX  = 6'd9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input value and the radix
    logic div_start;   // start one division of the magnitude
    logic push;        // store the remainder, take the quotient
    logic emit_sign;   // load '-' into the output register
    logic rd;          // read the top of the digit stack
    logic emit_digit;  // load the read digit into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic mag_zero;
    logic count_full;
    logic count_zero;
    logic negative;
    logic out_free;
  } dp_status_t;

  // Digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {1'b0, d};
    if (d > DIGIT_DEC_MAX) begin
      return ext + CHAR_LETTER_OFS;
    end
    return ext + CHAR_ZERO;
  endfunction

endpackage

### hdl/itrd_div.sv
// ---------------------------------------------------------------------------
// itrd_div
// Restoring divider that divides the magnitude by the radix, one quotient
// bit per cycle.
// ---------------------------------------------------------------------------
module itrd_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [VALUE_WIDTH-1:0]            dividend,
  input  logic [itrd_pkg::RADIX_W-1:0]      divisor,
  output logic                              done,
  output logic [VALUE_WIDTH-1:0]            quotient,
  output logic [itrd_pkg::DIGIT_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic                           busy;
  logic [CNT_W-1:0]               cnt;
  logic [itrd_pkg::DIGIT_W:0]     trial;
  logic [itrd_pkg::DIGIT_W:0]     div_ext;
  logic                           fits;

  // Shift the next dividend bit into the partial remainder and compare.
  assign trial   = {remainder, quotient[VALUE_WIDTH-1]};
  assign div_ext = {1'b0, divisor};
  assign fits    = (trial >= div_ext);

  // Control: bit counter, busy flag and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient <= {quotient[VALUE_WIDTH-2:0], fits};
      if (fits) begin
        remainder <= itrd_pkg::DIGIT_W'(trial - div_ext);
      end else begin
        remainder <= trial[itrd_pkg::DIGIT_W-1:0];
      end
    end
  end

endmodule

### hdl/itrd_dpath.sv
// ---------------------------------------------------------------------------
// itrd_dpath
// Datapath: radix register, magnitude, digit stack, divider and the output
// register.
// ---------------------------------------------------------------------------
module itrd_dpath #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_en,
  input  logic [itrd_pkg::RADIX_W-1:0]      cfg_write_data,
  input  logic [VALUE_WIDTH-1:0]            value,
  input  itrd_pkg::ctrl_cmd_t               cmd,
  output itrd_pkg::dp_status_t              status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]       char_code,
  output logic                              last
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  logic [itrd_pkg::RADIX_W-1:0]   radix;
  logic [itrd_pkg::RADIX_W-1:0]   radix_use;
  logic [VALUE_WIDTH-1:0]         magnitude;
  logic                           negative;
  logic [CNT_W-1:0]               digit_count;
  logic [itrd_pkg::DIGIT_W-1:0]   digit_stack [MAX_DIGITS];
  logic [itrd_pkg::DIGIT_W-1:0]   rd_digit;
  logic [CNT_W-1:0]               count_dec;
  logic                           div_done;
  logic [VALUE_WIDTH-1:0]         quotient;
  logic [itrd_pkg::DIGIT_W-1:0]   remainder;

  assign count_dec = digit_count - 1'b1;

  // Radix register, written by the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itrd_pkg::RADIX_RESET;
    end else if (cfg_write_en) begin
      radix <= cfg_write_data;
    end
  end

  // Working magnitude, sign and the clamped radix of the current request.
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude   <= '0;
      negative    <= 1'b0;
      digit_count <= '0;
      radix_use   <= itrd_pkg::RADIX_RESET;
    end else if (cmd.load) begin
      negative    <= value[VALUE_WIDTH-1];
      magnitude   <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
      digit_count <= '0;
      if (radix < itrd_pkg::RADIX_MIN) begin
        radix_use <= itrd_pkg::RADIX_MIN;
      end else if (radix > itrd_pkg::RADIX_MAX) begin
        radix_use <= itrd_pkg::RADIX_MAX;
      end else begin
        radix_use <= radix;
      end
    end else if (cmd.push) begin
      magnitude   <= quotient;
      digit_count <= digit_count + 1'b1;
    end else if (cmd.rd) begin
      digit_count <= count_dec;
    end
  end

  // Digit stack: push at the count, pop from the top with a registered read.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      digit_stack[digit_count[IDX_W-1:0]] <= remainder;
    end
    if (cmd.rd) begin
      rd_digit <= digit_stack[count_dec[IDX_W-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_code <= itrd_pkg::CHAR_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= itrd_pkg::digit_char(rd_digit);
      last      <= (digit_count == '0);
    end
  end

  itrd_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (magnitude),
    .divisor   (radix_use),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // Status toward the controller.
  always_comb begin
    status.div_done   = div_done;
    status.mag_zero   = (magnitude == '0);
    status.count_full = (digit_count == CNT_W'(MAX_DIGITS));
    status.count_zero = (digit_count == '0);
    status.negative   = negative;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

### hdl/itrd_ctrl.sv
// ---------------------------------------------------------------------------
// itrd_ctrl
// Controller: sequences the division loop, the sign and the digit pops.
// ---------------------------------------------------------------------------
module itrd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  itrd_pkg::dp_status_t   status,
  output itrd_pkg::ctrl_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DIV_START = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
  localparam logic [2:0] ST_CHECK     = 3'd3;
  localparam logic [2:0] ST_SIGN      = 3'd4;
  localparam logic [2:0] ST_RD        = 3'd5;
  localparam logic [2:0] ST_LOAD      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.push   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.mag_zero && !status.count_full) begin
          state_next = ST_DIV_START;
        end else if (status.negative) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_RD;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          state_next     = status.count_zero ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/integer_to_radix_digits_core.sv
// ---------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts a signed integer to ASCII text in a configurable radix, most
// significant character first, with the final character flagged.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------
//   input    in_valid / in_ready    value (VALUE_WIDTH, signed)
//   output   out_valid / out_ready  char_code (7), last (1)
//   config   cfg_write_en           cfg_write_data (6) = radix
//
// One request at a time. Each digit takes one pass of the bit-serial divider;
// once all digits are divided, the sign (if negative) and then each digit
// follow, every digit read from the digit stack and then loaded into the
// output register.
// A new request is taken once the last character is in the output register.
// Reset is synchronous; the radix returns to 10. A stalled output holds the
// controller in place; the divider and stack are not affected.
// ---------------------------------------------------------------------------
module integer_to_radix_digits_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [itrd_pkg::RADIX_W-1:0]  cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itrd_pkg::CHAR_W-1:0]   char_code,
  output logic                          last
);

  itrd_pkg::ctrl_cmd_t  cmd;
  itrd_pkg::dp_status_t status;

  // Sequencer.
  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Conversion datapath.
  itrd_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .value          (value),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .char_code      (char_code),
    .last           (last)
  );

endmodule

### hdl/itrd_checker.sv
// ---------------------------------------------------------------------------
// itrd_checker
// Port-level checks of the integer to radix text converter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module itrd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [itrd_pkg::CHAR_W-1:0] char_code,
  input logic                        last
);

  logic                        out_stall;
  logic [itrd_pkg::CHAR_W:0]   out_word;
  logic                        is_minus;
  logic                        is_digit;
  logic                        is_letter;
  logic                        char_ok;

  // Decode the output character into its legal classes.
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {char_code, last};
  assign is_minus  = (char_code == itrd_pkg::CHAR_MINUS);
  assign is_digit  = (char_code >= itrd_pkg::CHAR_ZERO) && (char_code <= itrd_pkg::CHAR_NINE);
  assign is_letter = (char_code >= itrd_pkg::CHAR_UPPER_A) &&
                     (char_code <= itrd_pkg::CHAR_UPPER_Z);
  assign char_ok   = is_minus || is_digit || is_letter;

  // A stalled character holds its code and flag.
  `ITRD_ASSERT_CLK(a_out_hold, out_stall |=> (out_valid && $stable(out_word)), "stalled output changed")

  // Reset empties the output register.
  `ITRD_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "output valid after reset")

  // Only one request is in work at a time.
  `ITRD_ASSERT_CLK(a_one_request, (in_valid && in_ready) |=> !in_ready, "request taken while busy")

  // Every character is '-', a decimal digit or an uppercase letter.
  `ITRD_ASSERT_CLK(a_char_legal, out_valid |-> char_ok, "illegal character")

  // The minus sign never ends a number.
  `ITRD_ASSERT_CLK(a_minus_not_last, (out_valid && is_minus) |-> !last, "minus flagged last")

endmodule

bind integer_to_radix_digits_core itrd_checker u_itrd_checker (.*);

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to radix text converter. Signed
// integers are sent as requests under several radix settings, and every
// character that comes back is checked against text predicted in the bench.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int VALUE_W        = 32;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int ITEMS_PER_PASS = 21;
  localparam int RANDOM_PASSES  = 10;

  localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  // One request waiting to be sent, optionally held until all text is back.
  typedef struct {
    logic signed [VALUE_W-1:0] number;
    bit                        drain_first;
  } pending_t;

  // One expected output character.
  typedef struct {
    logic [itrd_pkg::CHAR_W-1:0] code;
    logic                        last;
  } text_char_t;

  logic                         clk;
  logic                         rst            = 1'b1;
  logic                         cfg_write_en   = 1'b0;
  logic [itrd_pkg::RADIX_W-1:0] cfg_write_data = '0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_W-1:0]    value          = '0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic [itrd_pkg::CHAR_W-1:0]  char_code;
  logic                         last;

  pending_t                     pending_values[$];
  text_char_t                   expected_chars[$];
  logic [itrd_pkg::RADIX_W-1:0] radix_shadow   = itrd_pkg::RADIX_RESET;
  logic                         in_accepted    = 1'b0;
  bit                           quiet          = 1'b0;
  int                           send_gap       = 0;
  int                           stall_left     = 0;
  int                           idle_cycles    = 0;
  int                           mismatch_count = 0;

  integer_to_radix_digits_core #(
    .VALUE_WIDTH(VALUE_W),
    .MAX_DIGITS (32)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .char_code     (char_code),
    .last          (last)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Print one line per mismatch and keep count.
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Append the expected text of one integer under the current radix.
  function automatic void push_radix_text(input logic signed [VALUE_W-1:0] n);
    logic [VALUE_W-1:0]           mag;
    logic [itrd_pkg::DIGIT_W-1:0] digits[$];
    logic [itrd_pkg::DIGIT_W-1:0] d;
    logic [itrd_pkg::RADIX_W-1:0] r;
    int unsigned                  base;
    text_char_t                   c;
    int                           i;
    r = radix_shadow;
    if (r < itrd_pkg::RADIX_MIN) begin
      r = itrd_pkg::RADIX_MIN;
    end
    if (r > itrd_pkg::RADIX_MAX) begin
      r = itrd_pkg::RADIX_MAX;
    end
    base = 32'(r);
    // The most negative value has no positive twin, so take it unsigned.
    mag = n;
    if (n < 0) begin
      mag = '0 - mag;
      c.code = itrd_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    if (mag == 0) begin
      digits.push_back('0);
    end
    while (mag != 0) begin
      digits.push_back(itrd_pkg::DIGIT_W'(mag % base));
      mag = mag / base;
    end
    // Most significant digit first.
    for (i = digits.size() - 1; i >= 0; i--) begin
      d = digits[i];
      if (d > itrd_pkg::DIGIT_DEC_MAX) begin
        c.code = {1'b0, d} + itrd_pkg::CHAR_LETTER_OFS;
      end else begin
        c.code = {1'b0, d} + itrd_pkg::CHAR_ZERO;
      end
      c.last = (i == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // Random integer, weighted toward short text but covering every bit.
  function automatic logic signed [VALUE_W-1:0] random_number();
    logic signed [VALUE_W-1:0] n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = $urandom;
      4, 5, 6: begin
        n = $urandom_range(0, 1000);
        if ($urandom_range(0, 1) == 1) begin
          n = -n;
        end
      end
      7: n = $signed($urandom_range(0, 80)) - 40;
      8: begin
        case ($urandom_range(0, 4))
          0: n = INT_MIN;
          1: n = INT_MAX;
          2: n = INT_MIN + 1;
          3: n = -1;
          default: n = 0;
        endcase
      end
      default: begin
        n = 32'sd1 <<< $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) begin
          n = -n;
        end
      end
    endcase
    return n;
  endfunction

  task automatic queue_number(input logic signed [VALUE_W-1:0] n, input bit drain_first);
    pending_t p;
    p.number      = n;
    p.drain_first = drain_first;
    pending_values.push_back(p);
  endtask

  // Block until every request is sent and all of its text is back.
  task automatic wait_idle();
    @(posedge clk);
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the radix register while the block is idle.
  task automatic set_radix(input logic [itrd_pkg::RADIX_W-1:0] r);
    wait_idle();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= r;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Request driver: presents queued integers with random idle bursts.
  always @(negedge clk) begin : request_driver
    bit present;
    present = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // Hold the request until it is taken.
    end else begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_values.size() != 0 &&
                   !(pending_values[0].drain_first && expected_chars.size() != 0)) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
        end else begin
          value   <= pending_values.pop_front().number;
          present = 1'b1;
        end
      end
      in_valid <= present;
    end
  end

  // Result receiver: stalls the output in random bursts.
  always @(negedge clk) begin : result_receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: tracks the radix, predicts on each request, checks each character.
  always @(posedge clk) begin : monitor
    text_char_t want;
    if (rst) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid && in_ready;
      if (cfg_write_en) begin
        radix_shadow = cfg_write_data;
      end
      if (in_valid && in_ready) begin
        push_radix_text(value);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %h", char_code));
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code) begin
            report_mismatch($sformatf("char_code got %h want %h", char_code, want.code));
          end
          if (last !== want.last) begin
            report_mismatch($sformatf("last got %b want %b", last, want.last));
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    logic [itrd_pkg::RADIX_W-1:0] radix_list[$];
    logic [itrd_pkg::RADIX_W-1:0] r;
    int                           p;
    int                           i;

    radix_list = '{6'd2, 6'd3, 6'd7, 6'd8, 6'd16, 6'd0, 6'd63, 6'd36, 6'd10};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset radix: zero, signs and extremes.
    queue_number(0, 1'b0);
    queue_number(-1, 1'b0);
    queue_number(1, 1'b0);
    queue_number(9, 1'b0);
    queue_number(10, 1'b0);
    queue_number(INT_MAX, 1'b0);
    queue_number(INT_MIN, 1'b0);
    queue_number(-123456789, 1'b0);

    // Base 2 gives the longest text, 33 characters for the most negative value.
    set_radix(6'd2);
    queue_number(INT_MIN, 1'b0);
    queue_number(INT_MAX, 1'b0);
    queue_number(5, 1'b0);
    queue_number(-1, 1'b0);

    // Base 36 reaches the letter Z.
    set_radix(itrd_pkg::RADIX_MAX);
    queue_number(35, 1'b0);
    queue_number(36, 1'b0);
    queue_number(-35, 1'b0);
    queue_number(INT_MIN, 1'b0);
    queue_number(INT_MAX, 1'b0);

    // Out-of-range radix settings are clamped to the nearest legal base.
    set_radix(6'd0);
    queue_number(0, 1'b0);
    queue_number(6, 1'b0);
    set_radix(6'd63);
    queue_number(35, 1'b0);
    queue_number(-1296, 1'b0);
    set_radix(6'd1);
    queue_number(3, 1'b0);
    set_radix(6'd37);
    queue_number(71, 1'b0);

    // Random passes, each under its own radix; the last one runs without idling.
    for (p = 0; p < RANDOM_PASSES; p++) begin
      if (p < radix_list.size()) begin
        r = radix_list[p];
      end else begin
        r = $urandom_range(0, 63);
      end
      set_radix(r);
      if (p == RANDOM_PASSES - 1) begin
        quiet = 1'b1;
      end
      for (i = 0; i < ITEMS_PER_PASS; i++) begin
        queue_number(random_number(), (p == 1 && i == 10) || $urandom_range(0, 24) == 0);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/itrd_pkg.sv
hdl/itrd_div.sv
hdl/itrd_dpath.sv
hdl/itrd_ctrl.sv
hdl/integer_to_radix_digits_core.sv
hdl/itrd_checker.sv
dv/tb_top.sv
